@@ rtl/lzos_pkg.sv @@
// Package: constants, command codes and controller/datapath link types for the layer stack.
package lzos_pkg;

  localparam int NumLayers = 256;
  localparam int IdW       = 8;
  localparam int HW        = 9;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_SETH  = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic signed [HW-1:0] H_NONE = -9'sd1;
  localparam logic signed [HW-1:0] H_MAX  = 9'sd255;

  // Shift kinds.
  localparam logic [1:0] MV_DOWN = 2'd0;  // lower: slot[h] = slot[h-1], h descending
  localparam logic [1:0] MV_UP   = 2'd1;  // raise or hide: slot[h] = slot[h+1], h ascending
  localparam logic [1:0] MV_INS  = 2'd2;  // show: slot[h+1] = slot[h], h descending

  typedef struct packed {
    logic       load;      // latch the command word
    logic       clr;       // clearing pass: write one layer entry
    logic       scan_step; // allocate scan: advance
    logic       plan;      // compute clamp and shift plan
    logic       wr_shift;  // write read data at shifted slot
    logic       wr_final;  // write target id at its new height
    logic       finish;    // update top / bookkeeping, build result
  } ctl_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       scan_done;
    logic       noop;      // plan says nothing to move
    logic       shift_done;
    logic       is_alloc;
    logic       is_move;   // set-height or free
    logic       is_valid;  // set-height, or free of a shown layer
  } dp_stat_t;

endpackage

@@ rtl/layer_z_order_stack_unit.sv @@
// Top level: layer stacking unit, controller plus datapath.
// After reset a clearing pass marks every layer free and hidden; busy stays high.
// Allocate scans the in-use bits for a free layer, one entry a cycle; set-height/free
// read and write the order table once per moved layer; an unknown command goes to finish.
// One word at a time: busy is high until done, the next word is taken the cycle after.
// Reset (rst, sync): all layers free and hidden, top = -1; order table left unwritten.
module layer_z_order_stack_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd,
  input  logic [lzos_pkg::IdW-1:0]       layer_id,
  input  logic signed [10:0]             requested_height,
  output logic                           done,
  output logic                           status,
  output logic [lzos_pkg::IdW-1:0]       allocated_id,
  output logic signed [lzos_pkg::HW-1:0] final_height,
  output logic signed [lzos_pkg::HW-1:0] top_height,
  output logic                           redraw_needed,
  output logic [lzos_pkg::HW-1:0]        map_from_height,
  output logic [lzos_pkg::HW-1:0]        draw_from_height,
  output logic signed [lzos_pkg::HW-1:0] draw_to_height
);
  import lzos_pkg::*;

  ctl_cmd_t c;
  dp_stat_t s;

  // Sequencer: clear, decode, scan or plan and shift loop (read slot, write neighbor), finish.
  lzos_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .st(s), .cmd(c),
                    .busy(busy), .done(done));

  lzos_dp u_dp (
    .clk(clk), .rst(rst), .cmd_in(cmd), .layer_id(layer_id),
    .requested_height(requested_height), .cmd(c), .st(s),
    .status(status), .allocated_id(allocated_id), .final_height(final_height),
    .top_height(top_height), .redraw_needed(redraw_needed),
    .map_from_height(map_from_height), .draw_from_height(draw_from_height),
    .draw_to_height(draw_to_height)
  );

`ifndef SYNTHESIS
  // Result strobe is a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  // A result always comes while busy.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  // No redraw flags on a failed allocate.
  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !redraw_needed)
    else $error("redraw on failed allocate");
`endif
endmodule

@@ rtl/lzos_ram.sv @@
// Generic single-port RAM with registered read.
module lzos_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ rtl/lzos_ctrl.sv @@
// Controller state machine for the layer stack sequencer.
module lzos_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lzos_pkg::dp_stat_t st,
  output lzos_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import lzos_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_PLAN = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = start;
        if (start) state_next = S_DEC;
      end
      S_DEC: begin
        if (st.is_alloc)     state_next = S_SCAN;
        else if (st.is_move) state_next = S_PLAN;
        else                 state_next = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) state_next = S_FIN;
      end
      S_PLAN: begin
        cmd.plan = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        if (!st.is_valid || st.noop || st.shift_done) begin
          cmd.wr_final = st.is_valid && !st.noop;
          state_next = S_FIN;
        end else begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_shift = 1'b1;
        state_next = S_RD;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);
endmodule

@@ rtl/lzos_dp.sv @@
// Datapath: layer tables, order table RAM, clamp and shift cursor, result registers.
module lzos_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   cmd_in,
  input  logic [lzos_pkg::IdW-1:0]     layer_id,
  input  logic signed [10:0]           requested_height,
  input  lzos_pkg::ctl_cmd_t           cmd,
  output lzos_pkg::dp_stat_t           st,
  output logic                         status,
  output logic [lzos_pkg::IdW-1:0]     allocated_id,
  output logic signed [lzos_pkg::HW-1:0] final_height,
  output logic signed [lzos_pkg::HW-1:0] top_height,
  output logic                         redraw_needed,
  output logic [lzos_pkg::HW-1:0]      map_from_height,
  output logic [lzos_pkg::HW-1:0]      draw_from_height,
  output logic signed [lzos_pkg::HW-1:0] draw_to_height
);
  import lzos_pkg::*;

  logic signed [HW-1:0] top;

  logic [1:0]           c_cmd;
  logic [IdW-1:0]       c_id;
  logic signed [10:0]   c_req;

  logic signed [HW-1:0] old_h, tgt, cur, stop_h;
  logic [1:0]           mv;
  logic                 noop, hide, valid, scan_vld, scan_hit;
  logic [IdW:0]         rd_addr;   // next in_use entry the scan reads
  logic [IdW-1:0]       clr_addr, scan_id;

  // Order table, per-layer heights and in-use bits, one RAM each.
  logic                 o_we, h_we, u_we;
  logic [IdW-1:0]       o_addr, o_wdata, o_rdata;
  logic [IdW-1:0]       h_addr, u_addr;
  logic [HW-1:0]        h_wdata, h_rdata;
  logic                 u_wdata, u_rdata;

  lzos_ram #(.Width(IdW), .Depth(NumLayers)) u_order (
    .clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wdata), .rdata(o_rdata)
  );
  lzos_ram #(.Width(HW), .Depth(NumLayers)) u_hgt (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );
  lzos_ram #(.Width(1), .Depth(NumLayers)) u_used (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata)
  );

  // Clamp from latched command; old height comes from the read issued in decode.
  logic signed [HW-1:0] old_c, hcl;
  logic signed [11:0]   lim, rq, top_x;
  always_comb begin
    old_c = $signed(h_rdata);
    top_x = {{3{top[HW-1]}}, top};
    rq    = {c_req[10], c_req};
    if (c_cmd == CMD_FREE) rq = -12'sd1;
    lim   = (old_c >= 0) ? top_x : (top_x + 12'sd1);
    if (rq > lim) rq = lim;
    if (rq < -12'sd1) rq = -12'sd1;
    hcl = rq[HW-1:0];
  end

  wire is_alloc = (c_cmd == CMD_ALLOC);
  wire is_move  = (c_cmd == CMD_SETH) || (c_cmd == CMD_FREE);
  wire shift_done = (mv == MV_DOWN) ? (cur <= stop_h) :
                    (mv == MV_UP)   ? (cur >= stop_h) : (cur < stop_h);

  assign scan_id = rd_addr[IdW-1:0] - 8'd1;
  assign top_height = top;

  assign st.clr_done   = (clr_addr == IdW'(NumLayers - 1));
  assign st.scan_done  = scan_vld && (!u_rdata || rd_addr == (IdW+1)'(NumLayers));
  assign st.noop       = noop;
  assign st.shift_done = shift_done;
  assign st.is_alloc   = is_alloc;
  assign st.is_move    = is_move;
  assign st.is_valid   = valid;

  // Order RAM: read at source of current move, write at its destination.
  logic signed [HW-1:0] src, dst;
  always_comb begin
    case (mv)
      MV_DOWN: begin src = cur - 9'sd1; dst = cur; end
      MV_UP:   begin src = cur + 9'sd1; dst = cur; end
      default: begin src = cur;         dst = cur + 9'sd1; end
    endcase
    o_we    = cmd.wr_shift || (cmd.wr_final && !hide);
    o_addr  = cmd.wr_shift ? dst[IdW-1:0] : cmd.wr_final ? tgt[IdW-1:0] : src[IdW-1:0];
    o_wdata = cmd.wr_shift ? o_rdata : c_id;

    // Heights: default read at the addressed layer.
    h_we    = 1'b0;
    h_addr  = c_id;
    h_wdata = tgt;
    if (cmd.clr) begin
      h_we = 1'b1; h_addr = clr_addr; h_wdata = H_NONE;
    end else if (cmd.wr_shift) begin
      h_we = 1'b1; h_addr = o_rdata; h_wdata = dst;
    end else if (cmd.wr_final) begin
      h_we = 1'b1; h_addr = c_id; h_wdata = tgt;
    end else if (cmd.finish && is_alloc && scan_hit) begin
      h_we = 1'b1; h_addr = scan_id; h_wdata = H_NONE;
    end

    // In-use bits: default read at the scan address.
    u_we    = 1'b0;
    u_addr  = rd_addr[IdW-1:0];
    u_wdata = 1'b0;
    if (cmd.clr) begin
      u_we = 1'b1; u_addr = clr_addr; u_wdata = 1'b0;
    end else if (cmd.finish && is_alloc && scan_hit) begin
      u_we = 1'b1; u_addr = scan_id; u_wdata = 1'b1;
    end else if (cmd.finish && c_cmd == CMD_FREE) begin
      u_we = 1'b1; u_addr = c_id; u_wdata = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top              <= H_NONE;
      clr_addr         <= '0;
      status           <= 1'b0;
      allocated_id     <= '0;
      final_height     <= H_NONE;
      redraw_needed    <= 1'b0;
      map_from_height  <= '0;
      draw_from_height <= '0;
      draw_to_height   <= H_NONE;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + 8'd1;
      if (cmd.finish) begin
        status           <= 1'b0;
        allocated_id     <= '0;
        final_height     <= H_NONE;
        redraw_needed    <= 1'b0;
        map_from_height  <= '0;
        draw_from_height <= '0;
        draw_to_height   <= H_NONE;
        if (is_alloc) begin
          if (scan_hit) allocated_id <= scan_id;
          else status <= 1'b1;
        end else if (is_move) begin
          final_height <= (valid && !noop) ? tgt : old_h;
          if (valid && !noop) begin
            redraw_needed <= 1'b1;
            if (hide) begin
              if (top > H_NONE) top <= top - 9'sd1;
              draw_to_height <= old_h - 9'sd1;
            end else if (old_h > tgt) begin
              map_from_height  <= tgt + 9'sd1;
              draw_from_height <= tgt + 9'sd1;
              draw_to_height   <= old_h;
            end else begin
              if (old_h < 0) top <= top + 9'sd1;
              map_from_height  <= tgt;
              draw_from_height <= tgt;
              draw_to_height   <= tgt;
            end
          end
        end
      end
    end
    // Command latch, scan, shift cursor and plan: no reset needed.
    if (cmd.load) begin
      c_cmd    <= cmd_in;
      c_id     <= layer_id;
      c_req    <= requested_height;
      rd_addr  <= '0;
      scan_vld <= 1'b0;
      scan_hit <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (st.scan_done) scan_hit <= !u_rdata;
      else begin
        rd_addr  <= rd_addr + 9'd1;
        scan_vld <= 1'b1;
      end
    end
    if (cmd.wr_shift) begin
      case (mv)
        MV_DOWN: cur <= cur - 9'sd1;
        MV_UP:   cur <= cur + 9'sd1;
        default: cur <= cur - 9'sd1;
      endcase
    end
    if (cmd.plan) begin
      old_h <= old_c;
      tgt   <= hcl;
      hide  <= 1'b0;
      valid <= (c_cmd == CMD_SETH) || (old_c >= 0);
      noop  <= (old_c == hcl) || (old_c < 0 && top >= H_MAX);
      if (old_c > hcl) begin
        if (hcl >= 0) begin mv <= MV_DOWN; cur <= old_c; stop_h <= hcl; end
        else begin hide <= 1'b1; mv <= MV_UP; cur <= old_c; stop_h <= top; end
      end else if (old_c >= 0) begin
        mv <= MV_UP; cur <= old_c; stop_h <= hcl;
      end else begin
        mv <= MV_INS; cur <= top; stop_h <= hcl;
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
// Testbench top: drives the layer stack unit and checks every result word against a model.
`timescale 1ns / 1ps

module tb_top;
  import lzos_pkg::*;

  // The unnamed command code; the block must treat it as a no-op.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CycleLimit = 4_000_000;

  // One result word, widened to int so signed fields compare naturally.
  typedef struct {
    int st;
    int alloc;
    int fin;
    int topv;
    int redraw;
    int map_from;
    int draw_from;
    int draw_to;
  } stack_word_t;

  // Scoreboard: tracks the layer pool and stacking order, predicts each word.
  class layer_stack_sb;
    bit          used[NumLayers];
    int          hgt[NumLayers];
    logic [7:0]  order[NumLayers];
    int          top;
    int          peak_top;
    stack_word_t pending[$];
    int          errors;
    int          checked;
    stack_word_t w;

    function new();
      for (int i = 0; i < NumLayers; i++) begin
        used[i] = 0;
        hgt[i] = -1;
        order[i] = '0;
      end
      top = -1;
      peak_top = -1;
      errors = 0;
      checked = 0;
    endfunction

    function void place(int h, logic [7:0] id);
      order[h] = id;
      hgt[id] = h;
    endfunction

    function void flag_redraw(int mf, int df, int dt);
      w.redraw = 1;
      w.map_from = mf;
      w.draw_from = df;
      w.draw_to = dt;
    endfunction

    // Clamp the request, then shift the order table around the moved layer.
    function void restack(logic [7:0] id, int req);
      int old;
      int h;
      old = hgt[id];
      h = req;
      if (old >= 0) begin
        if (h > top) h = top;
      end else if (h > top + 1) begin
        h = top + 1;
      end
      if (h < -1) h = -1;
      if (old == h) return;
      if (old < 0 && top >= NumLayers - 1) return;
      if (old > h) begin
        if (h >= 0) begin
          for (int k = old; k > h; k--) place(k, order[k-1]);
          place(h, id);
          flag_redraw(h + 1, h + 1, old);
        end else begin
          for (int k = old; k < top; k++) place(k, order[k+1]);
          hgt[id] = -1;
          if (top > -1) top--;
          flag_redraw(0, 0, old - 1);
        end
      end else begin
        if (old >= 0) begin
          for (int k = old; k < h; k++) place(k, order[k+1]);
        end else begin
          for (int k = top; k >= h; k--) place(k + 1, order[k]);
          top++;
        end
        place(h, id);
        flag_redraw(h, h, h);
      end
    endfunction

    // Accepted command word: update the pool and queue the expected result.
    function void note_cmd(logic [1:0] c, logic [7:0] id, logic signed [10:0] rq);
      w = '{st: 0, alloc: 0, fin: -1, topv: 0, redraw: 0,
            map_from: 0, draw_from: 0, draw_to: -1};
      if (c == CMD_ALLOC) begin
        w.st = 1;
        for (int i = 0; i < NumLayers; i++) begin
          if (!used[i]) begin
            used[i] = 1;
            hgt[i] = -1;
            w.alloc = i;
            w.st = 0;
            break;
          end
        end
      end else if (c == CMD_SETH || c == CMD_FREE) begin
        if (c == CMD_SETH) begin
          restack(id, int'(rq));
        end else begin
          if (hgt[id] >= 0) restack(id, -1);
          used[id] = 0;
        end
        w.fin = hgt[id];
      end
      w.topv = top;
      if (top > peak_top) peak_top = top;
      pending.push_back(w);
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      end
    endfunction

    function void check(stack_word_t got);
      stack_word_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected", $time);
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("status", e.st, got.st);
      cmp("allocated_id", e.alloc, got.alloc);
      cmp("final_height", e.fin, got.fin);
      cmp("top_height", e.topv, got.topv);
      cmp("redraw_needed", e.redraw, got.redraw);
      cmp("map_from_height", e.map_from, got.map_from);
      cmp("draw_from_height", e.draw_from, got.draw_from);
      cmp("draw_to_height", e.draw_to, got.draw_to);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           cmd = CMD_ALLOC;
  logic [IdW-1:0]       layer_id = '0;
  logic signed [10:0]   requested_height = '0;
  logic                 done;
  logic                 status;
  logic [IdW-1:0]       allocated_id;
  logic signed [HW-1:0] final_height;
  logic signed [HW-1:0] top_height;
  logic                 redraw_needed;
  logic [HW-1:0]        map_from_height;
  logic [HW-1:0]        draw_from_height;
  logic signed [HW-1:0] draw_to_height;

  layer_stack_sb sb = new();
  int sent = 0;
  int cycles = 0;

  always #6 clk = ~clk;

  layer_z_order_stack_unit dut (
    .clk, .rst, .start, .busy, .cmd, .layer_id, .requested_height,
    .done, .status, .allocated_id, .final_height, .top_height,
    .redraw_needed, .map_from_height, .draw_from_height, .draw_to_height
  );

  // Result monitor: a word is valid for exactly the cycle done is high.
  always @(posedge clk) begin
    stack_word_t got;
    if (!rst && done) begin
      got.st = int'(status);
      got.alloc = int'(allocated_id);
      got.fin = int'($signed(final_height));
      got.topv = int'($signed(top_height));
      got.redraw = int'(redraw_needed);
      got.map_from = int'(map_from_height);
      got.draw_from = int'(draw_from_height);
      got.draw_to = int'($signed(draw_to_height));
      sb.check(got);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, sb.pending.size());
      $display("[layer_z_order_stack_unit] ERROR");
      $finish;
    end
  end

  // Present one command word and hold it until accepted. Start stays high
  // on return so back-to-back words need no extra edge; called at a posedge.
  task automatic issue(logic [1:0] c, logic [7:0] id, int h);
    start <= 1'b1;
    cmd <= c;
    layer_id <= id;
    requested_height <= 11'(h);
    do @(posedge clk); while (busy);
    sb.note_cmd(c, id, 11'(h));
    sent++;
  endtask

  task automatic pause_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender gap: one time in four, start is dropped and the sender idles before the next word.
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) pause_cycles($urandom_range(1, 4));
  endtask

  // Hold off until every expected word has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Random word: mostly meaningful restacks of low (allocated) layers,
  // with raw heights and stray ids mixed in to hit every field bit.
  task automatic random_word(bit gaps);
    int r;
    int id;
    int h;
    logic [1:0] c;
    r = $urandom_range(0, 99);
    if (r < 22) c = CMD_ALLOC;
    else if (r < 75) c = CMD_SETH;
    else if (r < 95) c = CMD_FREE;
    else c = CMD_NONE;
    id = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 60) h = $urandom_range(0, sb.top + 2);
    else if (r < 75) h = -1;
    else h = $signed(11'($urandom_range(0, 2047)));
    issue(c, 8'(id), h);
    if (gaps) maybe_gap();
  endtask

  initial begin
    int fails;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: show, insert, lower, raise, hide, clamps, no-ops, frees.
    repeat (4) issue(CMD_ALLOC, 8'd0, 0);
    issue(CMD_SETH, 8'd0, 5);        // clamps to top+1 on an empty stack
    issue(CMD_SETH, 8'd1, 1023);     // largest request, lands on top+1
    issue(CMD_SETH, 8'd2, 0);        // insert at the bottom
    maybe_gap();
    issue(CMD_SETH, 8'd0, -1024);    // most negative request hides
    issue(CMD_SETH, 8'd2, 0);        // same height, nothing moves
    issue(CMD_SETH, 8'd1, 0);        // lower
    issue(CMD_SETH, 8'd2, 1023);     // raise of the top layer clamps to top, nothing moves
    issue(CMD_SETH, 8'd3, -1);       // hidden stays hidden
    issue(CMD_SETH, 8'd200, 0);      // layer never allocated, still acts
    issue(CMD_FREE, 8'd200, 0);      // free a shown layer
    issue(CMD_FREE, 8'd3, 0);        // free a hidden layer
    issue(CMD_NONE, 8'd255, -1);     // unknown command
    issue(CMD_FREE, 8'd255, 1023);   // top id, unused and hidden
    issue(CMD_SETH, 8'd1, -1);
    issue(CMD_SETH, 8'd2, -1);       // stack empties again
    issue(CMD_SETH, 8'd0, -1);
    drain();

    // Fill the pool: allocate until it fails, then show every layer.
    fails = 0;
    while (fails < 2) begin
      issue(CMD_ALLOC, 8'($urandom_range(0, 255)), $urandom_range(0, 9));
      if (sb.used[NumLayers-1]) fails++;
      maybe_gap();
    end
    for (int i = 0; i < NumLayers; i++) begin
      issue(CMD_SETH, 8'(i), $urandom_range(0, sb.top + 1));
      maybe_gap();
    end
    issue(CMD_ALLOC, 8'd0, 0);       // pool exhausted
    issue(CMD_SETH, 8'd17, 1023);    // full stack, raise to top
    drain();

    // Random traffic with sender gaps, then a stretch back to back.
    for (int i = 0; i < 800; i++) random_word(1'b1);
    drain();
    for (int i = 0; i < 150; i++) random_word(1'b0);
    drain();
    pause_cycles(600);

    $display("Sent %0d command words, checked %0d result words; deepest stack top %0d.",
             sent, sb.checked, sb.peak_top);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[layer_z_order_stack_unit] OK");
    end else begin
      $display("[layer_z_order_stack_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lzos_pkg.sv
rtl/lzos_ram.sv
rtl/lzos_ctrl.sv
rtl/lzos_dp.sv
rtl/layer_z_order_stack_unit.sv
tb/tb_top.sv
